@@ hw/rtl/rdq_pkg.sv @@
`default_nettype none

package rdq_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned STATUS_W = 2;

  // Operation codes carried by func
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ROT_LEFT   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ROT_RIGHT  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DUMP       = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Ring read address source
  typedef enum logic [1:0] {
    RD_FRONT,
    RD_TAIL,
    RD_K
  } rd_sel_e;

  // Ring write address source
  typedef enum logic {
    WR_FRONT_M1,
    WR_BACK
  } wr_sel_e;

  // Ring write data source
  typedef enum logic {
    WD_VALUE,
    WD_RDATA
  } wd_sel_e;

  // Front index update
  typedef enum logic [1:0] {
    FR_HOLD,
    FR_DEC,
    FR_INC
  } fr_op_e;

  typedef struct packed {
    rd_sel_e               rd_sel;
    logic                  we;
    wr_sel_e               wr_sel;
    wd_sel_e               wd_sel;
    fr_op_e                fr_op;
    logic                  cnt_inc;
    logic                  k_load;
    logic                  k_inc;
    logic                  emit;
    logic                  emit_rdata;
    logic [STATUS_W-1:0]   emit_status;
    logic                  emit_last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic k_last;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/rdq_ram.sv @@
`default_nettype none

module rdq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/rdq_ctrl.sv @@
`default_nettype none

module rdq_ctrl
  import rdq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire sts_t              sts_i,
  output      cmd_t              cmd_o,
  output      logic              busy_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROTL = 2'd1;
  localparam logic [1:0] S_ROTR = 2'd2;
  localparam logic [1:0] S_DUMP = 2'd3;

  logic [1:0] state_q, state_d;
  cmd_t       cmd;

  always_comb begin
    state_d         = state_q;
    cmd             = '0;
    cmd.rd_sel      = RD_FRONT;
    cmd.wr_sel      = WR_BACK;
    cmd.wd_sel      = WD_VALUE;
    cmd.fr_op       = FR_HOLD;
    cmd.emit_status = STATUS_OK;
    cmd.emit_last   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd.emit = 1'b1;
          unique case (func_i)
            FUNC_PUSH_FRONT: begin
              if (sts_i.full) begin
                cmd.emit_status = STATUS_FULL;
              end else begin
                cmd.we      = 1'b1;
                cmd.wr_sel  = WR_FRONT_M1;
                cmd.fr_op   = FR_DEC;
                cmd.cnt_inc = 1'b1;
              end
            end
            FUNC_PUSH_BACK: begin
              if (sts_i.full) begin
                cmd.emit_status = STATUS_FULL;
              end else begin
                cmd.we      = 1'b1;
                cmd.cnt_inc = 1'b1;
              end
            end
            FUNC_ROT_LEFT: begin
              if (!sts_i.empty) begin
                cmd.emit = 1'b0;
                state_d  = S_ROTL;
              end
            end
            FUNC_ROT_RIGHT: begin
              if (!sts_i.empty) begin
                cmd.emit   = 1'b0;
                cmd.rd_sel = RD_TAIL;
                state_d    = S_ROTR;
              end
            end
            FUNC_DUMP: begin
              if (sts_i.empty) begin
                cmd.emit_status = STATUS_EMPTY;
              end else begin
                cmd.emit   = 1'b0;
                cmd.k_load = 1'b1;
                state_d    = S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ROTL: begin
        cmd.we     = 1'b1;
        cmd.wd_sel = WD_RDATA;
        cmd.fr_op  = FR_INC;
        cmd.emit   = 1'b1;
        state_d    = S_IDLE;
      end
      S_ROTR: begin
        cmd.we     = 1'b1;
        cmd.wr_sel = WR_FRONT_M1;
        cmd.wd_sel = WD_RDATA;
        cmd.fr_op  = FR_DEC;
        cmd.emit   = 1'b1;
        state_d    = S_IDLE;
      end
      S_DUMP: begin
        cmd.emit       = 1'b1;
        cmd.emit_rdata = 1'b1;
        cmd.emit_last  = sts_i.k_last;
        if (sts_i.k_last) begin
          state_d = S_IDLE;
        end else begin
          cmd.rd_sel = RD_K;
          cmd.k_inc  = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/rdq_dp.sv @@
`default_nettype none

module rdq_dp
  import rdq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic signed [DATA_W-1:0]   value_i,
  input  wire cmd_t                       cmd_i,
  output      sts_t                       sts_o,
  output      logic                       strobe_o,
  output      logic signed [DATA_W-1:0]   data_o,
  output      logic [STATUS_W-1:0]        status_o,
  output      logic                       last_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [SW-1:0] CapS  = SW'(CAPACITY);
  localparam logic [CW-1:0] CapC  = CW'(CAPACITY);
  localparam logic [CW-1:0] CapM1 = CW'(CAPACITY - 1);

  // base < CAPACITY and off <= CAPACITY, so one subtract wraps the sum
  function automatic logic [IW-1:0] ring_pos(logic [IW-1:0] base, logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= CapS) begin
      sum = sum - CapS;
    end
    return sum[IW-1:0];
  endfunction

  logic [IW-1:0]       front_q, front_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       k_q, k_d;
  logic [IW-1:0]       front_m1, front_p1, back_pos, tail_pos, k_pos;
  logic [IW-1:0]       raddr, waddr;
  logic [DATA_W-1:0]   wdata, rdata;
  logic                strobe_q;
  logic [DATA_W-1:0]   data_q;
  logic [STATUS_W-1:0] status_q;
  logic                last_q;

  assign front_m1 = ring_pos(front_q, CapM1);
  assign front_p1 = ring_pos(front_q, CW'(1));
  assign back_pos = ring_pos(front_q, count_q);
  assign tail_pos = ring_pos(front_q, count_q - CW'(1));
  assign k_pos    = ring_pos(front_q, k_q);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_TAIL: raddr = tail_pos;
      RD_K:    raddr = k_pos;
      default: raddr = front_q;
    endcase
    waddr = (cmd_i.wr_sel == WR_FRONT_M1) ? front_m1 : back_pos;
    wdata = (cmd_i.wd_sel == WD_RDATA) ? rdata : value_i;
    case (cmd_i.fr_op)
      FR_DEC:  front_d = front_m1;
      FR_INC:  front_d = front_p1;
      default: front_d = front_q;
    endcase
    count_d = cmd_i.cnt_inc ? count_q + CW'(1) : count_q;
    if (cmd_i.k_load) begin
      k_d = CW'(1);
    end else if (cmd_i.k_inc) begin
      k_d = k_q + CW'(1);
    end else begin
      k_d = k_q;
    end
  end

  rdq_ram #(
    .Width(DATA_W),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      k_q      <= '0;
      strobe_q <= 1'b0;
    end else begin
      front_q  <= front_d;
      count_q  <= count_d;
      k_q      <= k_d;
      strobe_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      data_q   <= cmd_i.emit_rdata ? rdata : '0;
      status_q <= cmd_i.emit_status;
      last_q   <= cmd_i.emit_last;
    end
  end

  assign sts_o.full   = (count_q == CapC);
  assign sts_o.empty  = (count_q == '0);
  assign sts_o.k_last = (k_q == count_q);

  assign strobe_o = strobe_q;
  assign data_o   = signed'(data_q);
  assign status_o = status_q;
  assign last_o   = last_q;

endmodule

`default_nettype wire

@@ hw/rtl/rotating_deque.sv @@
// Pushes (front or back), dropped pushes, empty rotates, empty dumps and unknown codes
// finish in idle: the result strobes in the cycle after the transaction and busy stays low.
// Rotates do a ring read, then a write-back at the other end (one RAM port each).
// A dump first does one registered RAM read, then emits one result per cycle.
// Reset clears front index, count and control; ring contents stay undefined until written.
// The receiver cannot stall: every result is presented for exactly one cycle.
`default_nettype none

module rotating_deque
  import rdq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output      logic                     busy,
  input  wire logic [FUNC_W-1:0]        func_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output      logic                     strobe_o,
  output      logic signed [DATA_W-1:0] data_o,
  output      logic [STATUS_W-1:0]      status_o,
  output      logic                     last_o
);

  // Command bundle from the sequencer and status back from the ring datapath
  cmd_t cmd;
  sts_t sts;
  logic ctrl_busy;

  // Sequencer: decode the transaction in idle, then hold for rotate or walk a dump
  rdq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .func_i (func_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (ctrl_busy)
  );

  // Datapath: ring RAM, front index, count, dump cursor and the result register
  rdq_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .value_i (value_i),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .strobe_o(strobe_o),
    .data_o  (data_o),
    .status_o(status_o),
    .last_o  (last_o)
  );

  // A new transaction is taken whenever the sequencer is back in idle, even while the
  // previous result is still on the outputs.
  assign busy = ctrl_busy;

endmodule

`default_nettype wire

@@ tb/deque_checker.sv @@
module deque_checker
  import rdq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  input  wire logic                     busy,
  input  wire logic [FUNC_W-1:0]        func_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire logic                     strobe_o,
  input  wire logic signed [DATA_W-1:0] data_o,
  input  wire logic [STATUS_W-1:0]      status_o,
  input  wire logic                     last_o,
  output int unsigned                   pending_o,
  output int unsigned                   fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [STATUS_W-1:0]      status;
    logic                     last;
  } deque_word_t;

  logic signed [DATA_W-1:0] ring_mirror [CAPACITY];
  int unsigned              head_idx = 0;
  int unsigned              fill_count = 0;
  int unsigned              words_pending = 0;
  int unsigned              mismatch_count = 0;
  deque_word_t              awaited_words [$];

  assign pending_o    = words_pending;
  assign fail_count_o = mismatch_count;

  function automatic int unsigned ring_slot(input int unsigned base,
                                            input int unsigned offset);
    return (base + offset) % CAPACITY;
  endfunction

  // Advance the mirrored ring by one operation and queue the words it yields.
  task automatic apply_deque_op(input logic [FUNC_W-1:0] op,
                                input logic signed [DATA_W-1:0] val);
    deque_word_t word;
    int unsigned tail;
    word.data   = '0;
    word.status = STATUS_OK;
    word.last   = 1'b1;
    case (op)
      FUNC_PUSH_FRONT: begin
        if (fill_count >= CAPACITY) begin
          word.status = STATUS_FULL;
        end else begin
          head_idx = ring_slot(head_idx, CAPACITY - 1);
          ring_mirror[head_idx] = val;
          fill_count++;
        end
      end
      FUNC_PUSH_BACK: begin
        if (fill_count >= CAPACITY) begin
          word.status = STATUS_FULL;
        end else begin
          ring_mirror[ring_slot(head_idx, fill_count)] = val;
          fill_count++;
        end
      end
      FUNC_ROT_LEFT: begin
        if (fill_count != 0) begin
          ring_mirror[ring_slot(head_idx, fill_count)] = ring_mirror[head_idx];
          head_idx = ring_slot(head_idx, 1);
        end
      end
      FUNC_ROT_RIGHT: begin
        if (fill_count != 0) begin
          tail = ring_slot(head_idx, fill_count - 1);
          head_idx = ring_slot(head_idx, CAPACITY - 1);
          ring_mirror[head_idx] = ring_mirror[tail];
        end
      end
      FUNC_DUMP: begin
        if (fill_count == 0) begin
          word.status = STATUS_EMPTY;
        end else begin
          for (int unsigned k = 0; k < fill_count; k++) begin
            word.data = ring_mirror[ring_slot(head_idx, k)];
            word.last = (k + 1 == fill_count);
            awaited_words.push_back(word);
          end
          return;
        end
      end
      default: ;
    endcase
    awaited_words.push_back(word);
  endtask

  // Check results before predicting: a word on the port always belongs to an
  // older transaction than one accepted on the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    deque_word_t want;
    if (!rst_ni) begin
      head_idx   = 0;
      fill_count = 0;
      awaited_words.delete();
    end else begin
      if (strobe_o) begin
        if (awaited_words.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual data %h status %0d last %0b",
                   $time, data_o, status_o, last_o);
          mismatch_count++;
        end else begin
          want = awaited_words.pop_front();
          if (data_o !== want.data) begin
            $display("%0t: data expected %h actual %h", $time, want.data, data_o);
            mismatch_count++;
          end
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            mismatch_count++;
          end
          if (last_o !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, last_o);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        apply_deque_op(func_i, value_i);
      end
    end
    words_pending = awaited_words.size();
  end

endmodule

@@ tb/rotating_deque_test.sv @@
module rotating_deque_test
  import rdq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY     = 64;
  // A full dump is the longest run of results: one read, then one result per element.
  localparam int unsigned DRAIN_CYCLES = CAPACITY + 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_OPS   = 170;

  logic                     clk_i   = 1'b0;
  logic                     rst_ni  = 1'b0;
  logic                     start   = 1'b0;
  logic [FUNC_W-1:0]        func_i  = '0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     busy;
  logic                     strobe_o;
  logic signed [DATA_W-1:0] data_o;
  logic [STATUS_W-1:0]      status_o;
  logic                     last_o;
  int unsigned              words_pending;
  int unsigned              mismatch_total;
  int unsigned              cycle_count = 0;

  rotating_deque #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .func_i  (func_i),
    .value_i (value_i),
    .strobe_o(strobe_o),
    .data_o  (data_o),
    .status_o(status_o),
    .last_o  (last_o)
  );

  // The checker mirrors the ring, scores every strobed word, and reports
  // how many words are still owed and how many checks failed.
  deque_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .func_i      (func_i),
    .value_i     (value_i),
    .strobe_o    (strobe_o),
    .data_o      (data_o),
    .status_o    (status_o),
    .last_o      (last_o),
    .pending_o   (words_pending),
    .fail_count_o(mismatch_total)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result must still end the run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Present one transaction and hold it until the block takes it. Start is
  // left high on return so a back-to-back transaction never drops it.
  task automatic issue_op(input logic [FUNC_W-1:0] op,
                          input logic signed [DATA_W-1:0] val);
    start   <= 1'b1;
    func_i  <= op;
    value_i <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Drop start about one time in seven.
  task automatic maybe_idle(input bit allow);
    if (allow && $urandom_range(0, 99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Hold off new transactions until every owed word has been strobed.
  // Sample the count on the falling edge so the checker has settled.
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk_i); while (words_pending != 0);
    @(posedge clk_i);
  endtask

  initial begin
    logic [FUNC_W-1:0]        op;
    logic signed [DATA_W-1:0] val;
    int unsigned              pick;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every empty-deque case first, since the deque never shrinks.
    issue_op(FUNC_DUMP, 32'sh1234_5678);
    issue_op(FUNC_ROT_LEFT, '0);
    maybe_idle(1'b1);
    issue_op(FUNC_ROT_RIGHT, '1);
    for (int c = FUNC_DUMP + 1; c < 2 ** FUNC_W; c++) begin
      issue_op(FUNC_W'(c), $urandom);
    end

    // Field extremes and a dump, then rotations in both directions, each direction followed by a dump.
    issue_op(FUNC_PUSH_FRONT, 32'sh7FFF_FFFF);
    issue_op(FUNC_PUSH_BACK, 32'sh8000_0000);
    issue_op(FUNC_PUSH_FRONT, '0);
    maybe_idle(1'b1);
    issue_op(FUNC_PUSH_BACK, '1);
    issue_op(FUNC_PUSH_FRONT, 32'shAAAA_AAAA);
    issue_op(FUNC_PUSH_BACK, 32'sh5555_5555);
    issue_op(FUNC_DUMP, '0);
    issue_op(FUNC_ROT_LEFT, $urandom);
    issue_op(FUNC_DUMP, $urandom);
    maybe_idle(1'b1);
    issue_op(FUNC_ROT_RIGHT, $urandom);
    issue_op(FUNC_ROT_RIGHT, $urandom);
    issue_op(FUNC_DUMP, '0);

    // Random: pushes dominate so the ring fills about two thirds of the way
    // in; the remainder then exercises full pushes, wrapped rotations and
    // full-length dumps.
    for (int unsigned n = 0; n < RANDOM_OPS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        op = ($urandom_range(0, 1) != 0) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
      end else if (pick < 80) begin
        op = ($urandom_range(0, 1) != 0) ? FUNC_ROT_LEFT : FUNC_ROT_RIGHT;
      end else if (pick < 92) begin
        op = FUNC_DUMP;
      end else begin
        op = FUNC_W'(FUNC_DUMP + $urandom_range(1, 3));
      end
      case ($urandom_range(0, 9))
        0:       val = 32'sh8000_0000;
        1:       val = 32'sh7FFF_FFFF;
        2:       val = '0;
        3:       val = '1;
        default: val = $urandom;
      endcase
      issue_op(op, val);
      // Let the block run dry once mid-stream.
      if (n == RANDOM_OPS / 2) begin
        drain_results();
      end
      // Keep one long stretch fully back to back.
      maybe_idle(n < 100 || n >= 140);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_total == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/rdq_pkg.sv
hw/rtl/rdq_ram.sv
hw/rtl/rdq_ctrl.sv
hw/rtl/rdq_dp.sv
hw/rtl/rotating_deque.sv
tb/deque_checker.sv
tb/rotating_deque_test.sv
